### src/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Types and codes shared by the sorted ranking table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  typedef enum logic [2:0] {
    MODE_INSERT     = 3'd0,
    MODE_DELETE     = 3'd1,
    MODE_READ       = 3'd2,
    MODE_BUMP       = 3'd3,
    MODE_SET_POINTS = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_BAD       = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_LOAD   = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [63:0]        key;
    logic [63:0]        cls;
    logic [15:0]        count;
    logic signed [31:0] points;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    logic     clear;
    logic     find_key;
  } cell_cmd_t;

endpackage

`default_nettype wire

### src/srt_cell.sv
// ----------------------------------------------------------------------------
// srt_cell
// One table slot: holds an entry, flags a hit and passes the seen wave on.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srt_pkg::cell_cmd_t cmd_i,
  input  srt_pkg::entry_t   new_i,
  input  srt_pkg::entry_t   left_i,
  input  srt_pkg::entry_t   right_i,
  input  logic              occupied_i,
  input  logic              seen_i,
  output logic              seen_o,
  output srt_pkg::entry_t   entry_o
);
  import srt_pkg::*;

  entry_t entry_q, entry_d;
  logic   seen_q;
  logic   hit;

  // delete looks for the key, insert for the first slot that is free or not smaller
  always_comb begin
    if (cmd_i.find_key) begin
      hit = occupied_i && (entry_q.key == new_i.key);
    end else begin
      hit = !occupied_i || (entry_q.count >= new_i.count);
    end
  end

  assign seen_o  = seen_q | hit;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (seen_q) begin
          entry_d = left_i;
        end else if (hit) begin
          entry_d = new_i;
        end
      end
      OP_DELETE: begin
        if (seen_o) begin
          entry_d = right_i;
        end
      end
      OP_LOAD: entry_d = new_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (cmd_i.clear) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

### src/sorted_ranking_table.sv
// ----------------------------------------------------------------------------
// sorted_ranking_table
// Ranking table kept in ascending order of adventure count in a row of cells.
// ----------------------------------------------------------------------------
// Each operation runs from acceptance through a scan state and then an update
// state: in the scan a seen bit ripples through the row of cells one cell per
// cycle to find the first matching slot, then the update shifts the cells from
// that slot on by one place for insert or delete, or loads the head cell for bump
// or a valid set points, and registers the result. One item is in work at a time;
// the next is taken in the cycle after the result has been delivered. The status
// tells ok, not found, table full, table empty or bad value; entry_total is the
// number of entries held afterwards, kept to five bits.
`default_nettype none

module sorted_ranking_table #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic [63:0]        entry_key_i,
  input  logic [63:0]        class_tag_i,
  input  logic [15:0]        adventure_count_i,
  input  logic signed [31:0] point_value_i,
  input  logic [3:0]         rank_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [4:0]         entry_total_o,
  output logic [63:0]        out_key_o,
  output logic [63:0]        out_class_o,
  output logic [15:0]        out_count_o,
  output logic signed [31:0] out_points_o
);
  import srt_pkg::*;

  localparam int FillW = $clog2(DEPTH + 1);
  localparam int CntW  = $clog2(DEPTH);
  localparam int CmpW  = FillW + 4;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   scan_cnt_q;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [2:0]        mode_q;
  logic [3:0]        rank_q;
  entry_t            req_q;

  logic              out_valid_q;
  logic [2:0]        status_q, status_d;
  logic [4:0]        total_q;
  entry_t            out_q, out_d;

  entry_t            cell_entry [DEPTH];
  logic [DEPTH-1:0]  seen_out;
  logic [DEPTH-1:0]  occupied;
  entry_t            new_bcast;
  entry_t            head_mod;
  entry_t            rank_entry;
  cell_cmd_t         body_cmd, head_cmd;
  cell_op_e          upd_op;
  logic              head_load;
  logic              in_acc;
  logic              empty, full, found, rank_ok, nonpos;
  logic [CmpW-1:0]   rank_ext, fill_ext;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;

  assign empty    = (fill_q == '0);
  assign full     = (fill_q == FillW'(DEPTH));
  assign found    = seen_out[DEPTH-1];
  assign rank_ext = CmpW'(rank_q);
  assign fill_ext = CmpW'(fill_q);
  assign rank_ok  = rank_ext < fill_ext;
  assign nonpos   = (req_q.points == '0) || req_q.points[31];

  // head after bump or set points, as the result reports it
  always_comb begin
    head_mod = cell_entry[0];
    if (mode_q == MODE_BUMP) begin
      if (cell_entry[0].count != 16'hFFFF) begin
        head_mod.count = cell_entry[0].count + 16'd1;
      end
    end else if (!nonpos) begin
      head_mod.points = req_q.points;
    end
  end

  always_comb begin
    rank_entry = cell_entry[0];
    for (int i = 0; i < DEPTH; i++) begin
      if (rank_ext == CmpW'(i)) begin
        rank_entry = cell_entry[i];
      end
    end
  end

  // decision taken in the update cycle, once the seen wave has settled
  always_comb begin
    status_d  = STAT_OK;
    fill_d    = fill_q;
    out_d     = '0;
    upd_op    = OP_HOLD;
    head_load = 1'b0;
    case (mode_q)
      MODE_INSERT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          upd_op = OP_INSERT;
          fill_d = fill_q + FillW'(1);
        end
      end
      MODE_DELETE: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else if (!found) begin
          status_d = STAT_NOT_FOUND;
        end else begin
          upd_op = OP_DELETE;
          fill_d = fill_q - FillW'(1);
        end
      end
      MODE_READ: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else if (!rank_ok) begin
          status_d = STAT_NOT_FOUND;
        end else begin
          out_d = rank_entry;
        end
      end
      MODE_BUMP: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          head_load = 1'b1;
          out_d     = head_mod;
        end
      end
      MODE_SET_POINTS: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          if (nonpos) begin
            status_d = STAT_BAD;
          end else begin
            head_load = 1'b1;
          end
          out_d = head_mod;
        end
      end
      default: status_d = STAT_BAD;
    endcase
  end

  always_comb begin
    body_cmd.clear    = (state_q == S_IDLE);
    body_cmd.find_key = (mode_q == MODE_DELETE);
    body_cmd.op       = (state_q == S_UPDATE) ? upd_op : OP_HOLD;
    head_cmd          = body_cmd;
    if ((state_q == S_UPDATE) && head_load) begin
      head_cmd.op = OP_LOAD;
    end
    new_bcast = ((mode_q == MODE_BUMP) || (mode_q == MODE_SET_POINTS)) ? head_mod : req_q;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign occupied[g] = FillW'(g) < fill_q;

    srt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      ((g == 0) ? head_cmd : body_cmd),
      .new_i      (new_bcast),
      .left_i     ((g == 0) ? new_bcast : cell_entry[(g == 0) ? 0 : g - 1]),
      .right_i    ((g == DEPTH - 1) ? new_bcast
                                    : cell_entry[(g == DEPTH - 1) ? g : g + 1]),
      .occupied_i (occupied[g]),
      .seen_i     ((g == 0) ? 1'b0 : seen_out[(g == 0) ? 0 : g - 1]),
      .seen_o     (seen_out[g]),
      .entry_o    (cell_entry[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_SCAN;
      S_SCAN:   if (scan_cnt_q == CntW'(DEPTH - 1)) state_d = S_UPDATE;
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        scan_cnt_q <= '0;
      end else if (state_q == S_SCAN) begin
        scan_cnt_q <= scan_cnt_q + CntW'(1);
      end
      if (state_q == S_UPDATE) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q        <= mode_i;
      rank_q        <= rank_index_i;
      req_q.key     <= entry_key_i;
      req_q.cls     <= class_tag_i;
      req_q.count   <= adventure_count_i;
      req_q.points  <= point_value_i;
    end
    if (state_q == S_UPDATE) begin
      status_q <= status_d;
      total_q  <= 5'(fill_d);
      out_q    <= out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_total_o = total_q;
  assign out_key_o     = out_q.key;
  assign out_class_o   = out_q.cls;
  assign out_count_o   = out_q.count;
  assign out_points_o  = out_q.points;

endmodule

`default_nettype wire

### sim/sorted_ranking_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_ranking_table_tb
// Self-checking bench for the sorted ranking table. A short table of directed
// items covers the empty, tie, saturation and bad-value cases. Random items
// follow in phases that fill, mix and drain the table. Results are checked
// against a shadow copy of the table kept in the bench or against typed values.
// ----------------------------------------------------------------------------

module sorted_ranking_table_tb;
  import srt_pkg::*;

  localparam int TBL_DEPTH    = 16;
  localparam int RANDOM_ITEMS = 1900;
  localparam int PHASE_LEN    = 100;
  localparam int QUIET_ITEMS  = 200;
  localparam int HOLD_PHASE   = 4;
  localparam int PAUSE_PHASE_A = 8;
  localparam int PAUSE_PHASE_B = 13;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 600000;

  localparam int KIND_FILL  = 0;
  localparam int KIND_MIX   = 1;
  localparam int KIND_DRAIN = 2;

  localparam logic [2:0]  MODE_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  MODE_RSVD_LAST  = 3'd7;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
  localparam logic signed [31:0] POINTS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POINTS_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0] mode;
    entry_t     ent;
    logic [3:0] rank;
  } op_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] total;
    entry_t     ent;
  } result_t;

  typedef struct {
    op_t     op;
    bit      typed;
    result_t want;
  } script_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         mode_i;
  logic [63:0]        entry_key_i;
  logic [63:0]        class_tag_i;
  logic [15:0]        adventure_count_i;
  logic signed [31:0] point_value_i;
  logic [3:0]         rank_index_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         status_o;
  logic [4:0]         entry_total_o;
  logic [63:0]        out_key_o;
  logic [63:0]        out_class_o;
  logic [15:0]        out_count_o;
  logic signed [31:0] out_points_o;

  // shadow copy of the ranking table
  entry_t  rank_tbl [TBL_DEPTH];
  int      rank_fill;
  result_t pending_results [$];
  logic [63:0] key_pool [8];
  int      fail_count;
  bit      quiet;
  bit      hold_req;

  sorted_ranking_table #(
    .DEPTH(TBL_DEPTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .entry_key_i      (entry_key_i),
    .class_tag_i      (class_tag_i),
    .adventure_count_i(adventure_count_i),
    .point_value_i    (point_value_i),
    .rank_index_i     (rank_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .entry_total_o    (entry_total_o),
    .out_key_o        (out_key_o),
    .out_class_o      (out_class_o),
    .out_count_o      (out_count_o),
    .out_points_o     (out_points_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // applies one item to the shadow table and returns its result
  function automatic result_t ranking_apply(input op_t op);
    result_t r;
    int      pos;
    int      i;
    r = '0;
    r.status = STAT_OK;
    case (op.mode)
      MODE_INSERT: begin
        if (rank_fill >= TBL_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          pos = 0;
          while (pos < rank_fill && rank_tbl[pos].count < op.ent.count) pos++;
          for (i = rank_fill; i > pos; i--) rank_tbl[i] = rank_tbl[i-1];
          rank_tbl[pos] = op.ent;
          rank_fill++;
        end
      end
      MODE_DELETE: begin
        if (rank_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          pos = 0;
          while (pos < rank_fill && rank_tbl[pos].key != op.ent.key) pos++;
          if (pos >= rank_fill) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            for (i = pos; i + 1 < rank_fill; i++) rank_tbl[i] = rank_tbl[i+1];
            rank_fill--;
          end
        end
      end
      MODE_READ: begin
        if (rank_fill == 0) r.status = STAT_EMPTY;
        else if (op.rank >= rank_fill) r.status = STAT_NOT_FOUND;
        else r.ent = rank_tbl[op.rank];
      end
      MODE_BUMP: begin
        if (rank_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // head count saturates, order is left as it is
          if (rank_tbl[0].count != COUNT_MAX) rank_tbl[0].count++;
          r.ent = rank_tbl[0];
        end
      end
      MODE_SET_POINTS: begin
        if (rank_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          if (op.ent.points <= 0) r.status = STAT_BAD;
          else rank_tbl[0].points = op.ent.points;
          r.ent = rank_tbl[0];
        end
      end
      default: r.status = STAT_BAD;
    endcase
    r.total = rank_fill[4:0];
    return r;
  endfunction

  function automatic op_t mk_op(input logic [2:0] m, input logic [63:0] k,
                                input logic [63:0] c, input logic [15:0] n,
                                input logic signed [31:0] p, input logic [3:0] r);
    op_t op;
    op.mode = m;
    op.ent.key = k;
    op.ent.cls = c;
    op.ent.count = n;
    op.ent.points = p;
    op.rank = r;
    return op;
  endfunction

  function automatic script_row_t typed_row(input op_t op, input logic [2:0] st,
                                            input logic [4:0] tot);
    script_row_t row;
    row.op = op;
    row.typed = 1'b1;
    row.want = '0;
    row.want.status = st;
    row.want.total = tot;
    return row;
  endfunction

  function automatic script_row_t plain_row(input op_t op);
    script_row_t row;
    row.op = op;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic logic [63:0] rand_key();
    if ($urandom_range(0, 1) == 0) return key_pool[$urandom_range(0, 7)];
    return {$urandom, $urandom};
  endfunction

  function automatic op_t rand_op(input int kind);
    op_t op;
    int  pick;
    int  ins_lim;
    int  del_lim;
    op.ent.key = rand_key();
    op.ent.cls = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    // small counts give lots of ties
    if (pick < 50) op.ent.count = 16'($urandom_range(0, 7));
    else if (pick < 85) op.ent.count = 16'($urandom);
    else op.ent.count = $urandom_range(0, 1) ? COUNT_MAX : 16'd0;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      op.ent.points = $urandom;
    end else begin
      case ($urandom_range(0, 4))
        0: op.ent.points = 0;
        1: op.ent.points = 1;
        2: op.ent.points = -1;
        3: op.ent.points = POINTS_MAX;
        default: op.ent.points = POINTS_MIN;
      endcase
    end
    if (rank_fill > 0 && $urandom_range(0, 9) < 6)
      op.rank = 4'($urandom_range(0, rank_fill - 1));
    else op.rank = 4'($urandom_range(0, 15));
    case (kind)
      KIND_FILL:  begin ins_lim = 55; del_lim = 65; end
      KIND_MIX:   begin ins_lim = 30; del_lim = 55; end
      KIND_DRAIN: begin ins_lim = 10; del_lim = 55; end
      default:    begin ins_lim = 30; del_lim = 55; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < ins_lim) begin
      op.mode = MODE_INSERT;
    end else if (pick < del_lim) begin
      op.mode = MODE_DELETE;
      // mostly delete something that is there
      if (rank_fill > 0 && $urandom_range(0, 3) != 0)
        op.ent.key = rank_tbl[$urandom_range(0, rank_fill - 1)].key;
    end else if (pick < 75) begin
      op.mode = MODE_READ;
    end else if (pick < 85) begin
      op.mode = MODE_BUMP;
    end else if (pick < 98) begin
      op.mode = MODE_SET_POINTS;
    end else begin
      op.mode = 3'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
    end
    return op;
  endfunction

  // starts and ends at a falling edge
  task automatic offer(input op_t op, input bit typed, input result_t want);
    result_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    mode_i            <= op.mode;
    entry_key_i       <= op.ent.key;
    class_tag_i       <= op.ent.cls;
    adventure_count_i <= op.ent.count;
    point_value_i     <= op.ent.points;
    rank_index_i      <= op.rank;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = ranking_apply(op);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result side
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected, status %0d", status_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (entry_total_o !== want.total) begin
          $error("entry_total: expected %0d, got %0d", want.total, entry_total_o);
          fail_count++;
        end
        if (out_key_o !== want.ent.key) begin
          $error("out_key: expected %h, got %h", want.ent.key, out_key_o);
          fail_count++;
        end
        if (out_class_o !== want.ent.cls) begin
          $error("out_class: expected %h, got %h", want.ent.cls, out_class_o);
          fail_count++;
        end
        if (out_count_o !== want.ent.count) begin
          $error("out_count: expected %0d, got %0d", want.ent.count, out_count_o);
          fail_count++;
        end
        if (out_points_o !== want.ent.points) begin
          $error("out_points: expected %0d, got %0d", want.ent.points, out_points_o);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls, one long hold-off on request
  initial begin : receiver
    int n;
    out_ready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        n = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 15);
      end else begin
        out_ready_i <= 1'b1;
        n = quiet ? 1 : $urandom_range(1, 20);
      end
      repeat (n) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("sorted_ranking_table_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    script_row_t script [$];
    int idx;
    int phase;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    mode_i            = '0;
    entry_key_i       = '0;
    class_tag_i       = '0;
    adventure_count_i = '0;
    point_value_i     = '0;
    rank_index_i      = '0;
    fail_count        = 0;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    rank_fill         = 0;
    for (idx = 0; idx < 8; idx++) key_pool[idx] = {$urandom, $urandom};

    // empty table and undefined modes
    script.push_back(typed_row(mk_op(MODE_READ, '0, '0, '0, 0, 4'd0), STAT_EMPTY, 5'd0));
    script.push_back(typed_row(mk_op(MODE_DELETE, '0, '0, '0, 0, 4'd0), STAT_EMPTY, 5'd0));
    script.push_back(typed_row(mk_op(MODE_BUMP, '0, '0, '0, 0, 4'd0), STAT_EMPTY, 5'd0));
    script.push_back(typed_row(mk_op(MODE_SET_POINTS, '0, '0, '0, 5, 4'd0), STAT_EMPTY,
                               5'd0));
    script.push_back(typed_row(mk_op(MODE_RSVD_FIRST, '1, '1, '1, -1, 4'hF), STAT_BAD, 5'd0));
    script.push_back(typed_row(mk_op(MODE_RSVD_LAST, '0, '0, '0, 0, 4'd0), STAT_BAD, 5'd0));
    // field extremes
    script.push_back(typed_row(mk_op(MODE_INSERT, '1, '1, COUNT_MAX, POINTS_MAX, 4'hF),
                               STAT_OK, 5'd1));
    script.push_back(typed_row(mk_op(MODE_INSERT, '0, '0, 16'd0, POINTS_MIN, 4'd0),
                               STAT_OK, 5'd2));
    // ties go in front of the equal count
    script.push_back(plain_row(mk_op(MODE_INSERT, 64'hA5A5_A5A5_A5A5_A5A5,
                                     64'h5A5A_5A5A_5A5A_5A5A, COUNT_MAX, -1, 4'd0)));
    script.push_back(plain_row(mk_op(MODE_INSERT, 64'd3, 64'hC3, 16'd0, 7, 4'd0)));
    script.push_back(plain_row(mk_op(MODE_READ, '0, '0, '0, 0, 4'd0)));
    script.push_back(plain_row(mk_op(MODE_READ, '0, '0, '0, 0, 4'd1)));
    script.push_back(plain_row(mk_op(MODE_READ, '0, '0, '0, 0, 4'd2)));
    script.push_back(plain_row(mk_op(MODE_READ, '0, '0, '0, 0, 4'd3)));
    script.push_back(plain_row(mk_op(MODE_READ, '0, '0, '0, 0, 4'd4)));
    script.push_back(plain_row(mk_op(MODE_READ, '0, '0, '0, 0, 4'hF)));
    script.push_back(plain_row(mk_op(MODE_BUMP, '0, '0, '0, 0, 4'd0)));
    // points of zero or less are refused
    script.push_back(plain_row(mk_op(MODE_SET_POINTS, '0, '0, '0, 0, 4'd0)));
    script.push_back(plain_row(mk_op(MODE_SET_POINTS, '0, '0, '0, -1, 4'd0)));
    script.push_back(plain_row(mk_op(MODE_SET_POINTS, '0, '0, '0, 1, 4'd0)));
    script.push_back(plain_row(mk_op(MODE_SET_POINTS, '0, '0, '0, POINTS_MAX, 4'd0)));
    script.push_back(plain_row(mk_op(MODE_DELETE, 64'h1234, '0, '0, 0, 4'd0)));
    script.push_back(plain_row(mk_op(MODE_DELETE, 64'd3, '0, '0, 0, 4'd0)));
    script.push_back(plain_row(mk_op(MODE_DELETE, 64'd0, '0, '0, 0, 4'd0)));
    // head now at the top count, bump must saturate
    script.push_back(plain_row(mk_op(MODE_BUMP, '0, '0, '0, 0, 4'd0)));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (idx = 0; idx < script.size(); idx++)
      offer(script[idx].op, script[idx].typed, script[idx].want);

    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      phase = idx / PHASE_LEN;
      if (idx % PHASE_LEN == 0) begin
        if (phase == HOLD_PHASE) hold_req = 1'b1;
        if (phase == PAUSE_PHASE_A || phase == PAUSE_PHASE_B) drain_results();
      end
      if (idx == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      offer(rand_op(phase % 3), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("sorted_ranking_table_tb: done, clean");
    end else begin
      $display("sorted_ranking_table_tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
src/srt_pkg.sv
src/srt_cell.sv
src/sorted_ranking_table.sv
sim/sorted_ranking_table_tb.sv
